### hw/rtl/mvp_pkg.sv
`default_nettype none

package mvp_pkg;

  localparam int VAL_W       = 32;
  localparam int ACC_W       = 64;
  localparam int COL_W       = 8;
  localparam int SIZE_W      = 9;
  localparam int DIGIT_W     = 8;
  localparam int NUM_CELLS   = VAL_W / DIGIT_W;
  localparam int MAX_DIM_DEF = 256;
  localparam int ADDR_LIMIT  = 256;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  localparam logic OP_VEC = 1'b0;
  localparam logic OP_MAT = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic                     op;
    logic [COL_W-1:0]         col;
    logic signed [VAL_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic [COL_W-1:0]         row;
    logic signed [ACC_W-1:0]  sum;
    logic                     saturated;
  } out_t;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

`default_nettype wire

### hw/rtl/mvp_vec_store.sv
`default_nettype none

module mvp_vec_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [AW-1:0]                   waddr,
  input  wire logic signed [mvp_pkg::VAL_W-1:0] wdata,
  input  wire logic                            re,
  input  wire logic [AW-1:0]                   raddr,
  output logic signed [mvp_pkg::VAL_W-1:0]      rdata
);
  import mvp_pkg::*;

  logic signed [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mvp_mac_cell.sv
`default_nettype none

module mvp_mac_cell #(
  parameter int IDX = 0
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             en,
  input  wire mvp_pkg::ctl_t                    ctl_in,
  input  wire logic signed [mvp_pkg::VAL_W-1:0] a_in,
  input  wire logic signed [mvp_pkg::VAL_W-1:0] b_in,
  input  wire logic signed [mvp_pkg::ACC_W-1:0] psum_in,
  output mvp_pkg::ctl_t                         ctl_out,
  output logic signed [mvp_pkg::VAL_W-1:0]      a_out,
  output logic signed [mvp_pkg::VAL_W-1:0]      b_out,
  output logic signed [mvp_pkg::ACC_W-1:0]      psum_out
);
  import mvp_pkg::*;

  localparam int  SHIFT = IDX * DIGIT_W;
  localparam bit  TOP   = (IDX == NUM_CELLS - 1);

  logic [DIGIT_W-1:0]                digit;
  logic signed [DIGIT_W:0]           digit_ext;
  logic signed [VAL_W+DIGIT_W:0]     prod;
  logic signed [ACC_W-1:0]           prod_ext;

  assign digit     = b_in[SHIFT +: DIGIT_W];
  assign digit_ext = TOP ? $signed({digit[DIGIT_W-1], digit}) : $signed({1'b0, digit});
  assign prod      = a_in * digit_ext;
  assign prod_ext  = ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_out    <= a_in;
      b_out    <= b_in;
      psum_out <= psum_in + (prod_ext <<< SHIFT);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mvp_accum.sv
`default_nettype none

module mvp_accum (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire mvp_pkg::ctl_t                     ctl,
  input  wire logic signed [mvp_pkg::ACC_W-1:0]  prod,
  input  wire logic [mvp_pkg::SIZE_W-1:0]        n_eff,
  input  wire logic                              out_stall,
  output logic                                   out_valid,
  output mvp_pkg::out_t                          out_data
);
  import mvp_pkg::*;

  logic signed [ACC_W-1:0] acc;
  logic                    overflow_seen;
  logic [COL_W-1:0]        row;

  logic signed [ACC_W-1:0] sum_raw;
  logic                    ovf_pos;
  logic                    ovf_neg;
  logic signed [ACC_W-1:0] acc_next;
  logic                    sat_next;
  logic [COL_W-1:0]        row_next;
  logic                    take;

  assign sum_raw  = acc + prod;
  assign ovf_pos  = !acc[ACC_W-1] && !prod[ACC_W-1] && sum_raw[ACC_W-1];
  assign ovf_neg  = acc[ACC_W-1] && prod[ACC_W-1] && !sum_raw[ACC_W-1];
  assign acc_next = ovf_pos ? ACC_MAX : (ovf_neg ? ACC_MIN : sum_raw);
  assign sat_next = overflow_seen | ovf_pos | ovf_neg;
  assign row_next = ({1'b0, row} >= (n_eff - SIZE_W'(1))) ? '0 : row + COL_W'(1);
  assign take     = en && ctl.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      overflow_seen <= 1'b0;
      row           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        if (ctl.last) begin
          acc           <= '0;
          overflow_seen <= 1'b0;
          row           <= row_next;
        end else begin
          acc           <= acc_next;
          overflow_seen <= sat_next;
        end
      end
      if (take && ctl.last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && ctl.last) begin
      out_data.row       <= row;
      out_data.sum       <= acc_next;
      out_data.saturated <= sat_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/matrix_vector_product.sv
// Path: a row-closing matrix element passes the input stage, the cells and the accumulator.
// Throughput: one item per cycle; the pipeline of four 32x8 multiply cells and the
//   accumulator stage all advance together and freeze only while a result waits under stall.
// Reset: synchronous, active high; clears row counter, accumulator, saturation flag and
//   pipeline valids, sets size_in_use to 256. The vector store is not cleared.
`default_nettype none

module matrix_vector_product #(
  parameter int MAX_DIM = mvp_pkg::MAX_DIM_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [mvp_pkg::SIZE_W-1:0]   cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire mvp_pkg::in_t                 in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output mvp_pkg::out_t                     out_data
);
  import mvp_pkg::*;

  localparam int DEPTH = (MAX_DIM < ADDR_LIMIT) ? MAX_DIM : ADDR_LIMIT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SIZE_W-1:0] NMAX = SIZE_W'(DEPTH);

  logic [SIZE_W-1:0] size_in_use;
  logic [SIZE_W-1:0] n_eff;
  logic              adv;
  logic              in_xfer;
  logic              col_ok;
  logic              vec_in_range;

  ctl_t                    s0_ctl;
  logic signed [VAL_W-1:0] s0_a;
  logic signed [VAL_W-1:0] s0_b;

  ctl_t                    c_ctl  [NUM_CELLS+1];
  logic signed [VAL_W-1:0] c_a    [NUM_CELLS+1];
  logic signed [VAL_W-1:0] c_b    [NUM_CELLS+1];
  logic signed [ACC_W-1:0] c_psum [NUM_CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
    end else if (cfg_write) begin
      size_in_use <= cfg_data;
    end
  end

  assign n_eff = (size_in_use == '0) ? SIZE_W'(1) :
                 ((size_in_use > NMAX) ? NMAX : size_in_use);

  assign in_stall     = out_valid && out_stall;
  assign adv          = !in_stall;
  assign in_xfer      = in_valid && !in_stall;
  assign col_ok       = {1'b0, in_data.col} < n_eff;
  assign vec_in_range = {1'b0, in_data.col} < NMAX;

  mvp_vec_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (in_xfer && (in_data.op == OP_VEC) && vec_in_range),
    .waddr (in_data.col[AW-1:0]),
    .wdata (in_data.value),
    .re    (in_xfer && (in_data.op == OP_MAT)),
    .raddr (in_data.col[AW-1:0]),
    .rdata (s0_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_ctl.valid <= 1'b0;
    end else if (adv) begin
      s0_ctl.valid <= in_xfer && (in_data.op == OP_MAT) && col_ok;
    end
    if (adv) begin
      s0_ctl.last <= ({1'b0, in_data.col} == (n_eff - SIZE_W'(1)));
      s0_a        <= in_data.value;
    end
  end

  assign c_ctl[0]  = s0_ctl;
  assign c_a[0]    = s0_a;
  assign c_b[0]    = s0_b;
  assign c_psum[0] = '0;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    mvp_mac_cell #(
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .ctl_in   (c_ctl[i]),
      .a_in     (c_a[i]),
      .b_in     (c_b[i]),
      .psum_in  (c_psum[i]),
      .ctl_out  (c_ctl[i+1]),
      .a_out    (c_a[i+1]),
      .b_out    (c_b[i+1]),
      .psum_out (c_psum[i+1])
    );
  end

  mvp_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .ctl       (c_ctl[NUM_CELLS]),
    .prod      (c_psum[NUM_CELLS]),
    .n_eff     (n_eff),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### hw/rtl/mvp_checker.sv
`default_nettype none

module mvp_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire mvp_pkg::out_t              out_data
);
  import mvp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_drop_only_on_transfer: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result dropped without transfer");

endmodule

bind matrix_vector_product mvp_checker u_mvp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_LEN     = 100;
  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] VAL_ONE = 32'h0001_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [mvp_pkg::SIZE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  mvp_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mvp_pkg::out_t out_data;

  int send_gap_pct = 13;
  int recv_stall_pct = 60;
  logic hold_req = 1'b0;
  int hold_cnt = 0;
  int failures = 0;
  int useful_items = 0;

  mvp_pkg::out_t expected_rows[$];
  mvp_pkg::out_t want;

  logic signed [31:0] vec_mem [256];
  bit vec_written [256];
  logic signed [63:0] row_sum_acc = '0;
  logic [7:0] next_row = '0;
  logic row_saturated = 1'b0;
  logic [8:0] dim_setting = mvp_pkg::SIZE_RESET;

  matrix_vector_product u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int dim_in_use();
    if (dim_setting == 0) return 1;
    if (dim_setting > mvp_pkg::MAX_DIM_DEF) return mvp_pkg::MAX_DIM_DEF;
    return int'(dim_setting);
  endfunction

  function automatic bit predict_row_sum(input mvp_pkg::in_t item, output mvp_pkg::out_t res);
    int n;
    logic signed [63:0] prod;
    logic [64:0] total;
    res = '0;
    n = dim_in_use();
    if (item.op == mvp_pkg::OP_VEC) begin
      vec_mem[item.col] = item.value;
      vec_written[item.col] = 1'b1;
      return 1'b0;
    end
    if (int'(item.col) >= n) return 1'b0;
    prod = $signed(item.value) * $signed(vec_mem[item.col]);
    total = {row_sum_acc[63], row_sum_acc} + {prod[63], prod};
    if (total[64] != total[63]) begin
      row_sum_acc = total[64] ? mvp_pkg::ACC_MIN : mvp_pkg::ACC_MAX;
      row_saturated = 1'b1;
    end else begin
      row_sum_acc = total[63:0];
    end
    if (int'(item.col) != n - 1) return 1'b0;
    res.row = next_row;
    res.sum = row_sum_acc;
    res.saturated = row_saturated;
    row_sum_acc = '0;
    row_saturated = 1'b0;
    if (int'(next_row) >= n - 1) begin
      next_row = '0;
    end else begin
      next_row = next_row + 8'd1;
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(15))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return '1;
      4, 5, 6: return 32'($urandom_range(131071)) - VAL_ONE;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input logic op, input int col, input logic [31:0] value);
    mvp_pkg::in_t item;
    mvp_pkg::out_t res;
    item.op = op;
    item.col = 8'(col);
    item.value = value;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (item.op == mvp_pkg::OP_VEC || int'(item.col) < dim_in_use()) useful_items++;
    if (predict_row_sum(item, res)) expected_rows.push_back(res);
    @(negedge clk);
  endtask

  task automatic send_noise(input int n);
    if ($urandom_range(1) == 1 && n < 256) begin
      send_item(mvp_pkg::OP_MAT, $urandom_range(255, n), rand_value());
    end else begin
      send_item(mvp_pkg::OP_VEC, $urandom_range(255), rand_value());
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_dimension(input logic [8:0] dim);
    cfg_write <= 1'b1;
    cfg_data <= dim;
    @(negedge clk);
    cfg_write <= 1'b0;
    dim_setting = dim;
  endtask

  task automatic test_saturation();
    wait_idle();
    set_dimension(9'd4);
    send_item(mvp_pkg::OP_VEC, 0, VAL_MIN);
    send_item(mvp_pkg::OP_VEC, 1, VAL_MIN);
    send_item(mvp_pkg::OP_VEC, 2, VAL_MAX);
    send_item(mvp_pkg::OP_VEC, 3, '1);
    send_item(mvp_pkg::OP_VEC, 255, 32'h1234_5678);
    // clamp high, then come back down
    send_item(mvp_pkg::OP_MAT, 0, VAL_MIN);
    send_item(mvp_pkg::OP_MAT, 1, VAL_MIN);
    send_item(mvp_pkg::OP_MAT, 2, VAL_MIN);
    send_item(mvp_pkg::OP_MAT, 3, '0);
    // clamp low
    send_item(mvp_pkg::OP_MAT, 0, VAL_MAX);
    send_item(mvp_pkg::OP_MAT, 1, VAL_MAX);
    send_item(mvp_pkg::OP_MAT, 2, VAL_MIN);
    send_item(mvp_pkg::OP_MAT, 3, VAL_MIN);
    // plain row with an out-of-range column in the middle
    send_item(mvp_pkg::OP_MAT, 0, VAL_ONE);
    send_item(mvp_pkg::OP_MAT, 1, '0);
    send_item(mvp_pkg::OP_MAT, 2, 32'hFFFF_0000);
    send_item(mvp_pkg::OP_MAT, 200, rand_value());
    send_item(mvp_pkg::OP_MAT, 3, VAL_MAX);
  endtask

  task automatic test_dimension_limits();
    // row counter is already past the last row of the new size
    wait_idle();
    set_dimension(9'd2);
    send_item(mvp_pkg::OP_MAT, 0, rand_value());
    send_item(mvp_pkg::OP_MAT, 1, rand_value());
    wait_idle();
    set_dimension(9'd0);
    send_item(mvp_pkg::OP_MAT, 0, rand_value());
    send_item(mvp_pkg::OP_MAT, 1, rand_value());
    wait_idle();
    set_dimension(9'd511);
    send_item(mvp_pkg::OP_MAT, 0, rand_value());
    send_item(mvp_pkg::OP_MAT, 255, rand_value());
  endtask

  task automatic test_backpressure();
    int saved_gap;
    int saved_stall;
    saved_gap = send_gap_pct;
    saved_stall = recv_stall_pct;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    wait_idle();
    set_dimension(9'd2);
    send_item(mvp_pkg::OP_VEC, 0, rand_value());
    send_item(mvp_pkg::OP_VEC, 1, rand_value());
    wait_idle();
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    repeat (24) begin
      send_item(mvp_pkg::OP_MAT, 0, rand_value());
      send_item(mvp_pkg::OP_MAT, 1, rand_value());
    end
    wait_idle();
    @(posedge clk);
    hold_req = 1'b0;
    @(negedge clk);
    send_gap_pct = saved_gap;
    recv_stall_pct = saved_stall;
  endtask

  task automatic test_random_rows(input int budget);
    int stop_at;
    int n;
    int c;
    int skip_col;
    int dup_col;
    logic [8:0] dim;
    stop_at = useful_items + budget;
    while (useful_items < stop_at) begin
      wait_idle();
      case ($urandom_range(19))
        0, 1, 2: dim = 9'($urandom_range(24, 9));
        3: dim = 9'($urandom_range(511, 256));
        4: dim = 9'd1;
        default: dim = 9'($urandom_range(8, 2));
      endcase
      set_dimension(dim);
      n = dim_in_use();
      if (n == 256) begin
        // sparse rows over written entries only
        send_item(mvp_pkg::OP_VEC, 255, rand_value());
        repeat (4) send_item(mvp_pkg::OP_VEC, $urandom_range(254), rand_value());
        repeat ($urandom_range(4, 2)) begin
          repeat ($urandom_range(5, 1)) begin
            do c = $urandom_range(254); while (!vec_written[c]);
            send_item(mvp_pkg::OP_MAT, c, rand_value());
          end
          if ($urandom_range(4) == 0) send_noise(n);
          send_item(mvp_pkg::OP_MAT, 255, rand_value());
        end
      end else begin
        for (int k = 0; k < n; k++) send_item(mvp_pkg::OP_VEC, k, rand_value());
        repeat ($urandom_range(8, 2)) begin
          skip_col = -1;
          dup_col = -1;
          if ($urandom_range(9) == 0) begin
            skip_col = $urandom_range(n - 1);
          end else if ($urandom_range(9) == 0) begin
            dup_col = $urandom_range(n - 1);
          end
          for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) send_noise(n);
            if (k != skip_col) send_item(mvp_pkg::OP_MAT, k, rand_value());
            if (k == dup_col) send_item(mvp_pkg::OP_MAT, k, rand_value());
          end
        end
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_req && hold_cnt < HOLD_LEN) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!hold_req) hold_cnt <= 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_rows.size() == 0) begin
        failures++;
        $error("row result with none pending: row %0d sum %0d", out_data.row, out_data.sum);
      end else begin
        want = expected_rows.pop_front();
        if (out_data.row !== want.row) begin
          failures++;
          $error("row: expected %0d, got %0d", want.row, out_data.row);
        end
        if (out_data.sum !== want.sum) begin
          failures++;
          $error("sum: expected %0d, got %0d", want.sum, out_data.sum);
        end
        if (out_data.saturated !== want.saturated) begin
          failures++;
          $error("saturated: expected %0b, got %0b", want.saturated, out_data.saturated);
        end
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_saturation();
    test_dimension_limits();
    test_backpressure();
    test_random_rows(130);
    send_gap_pct = 60;
    recv_stall_pct = 13;
    test_random_rows(130);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_random_rows(130);
    wait_idle();
    if (failures == 0 && expected_rows.size() == 0) begin
      $display("matrix_vector_product test passed");
    end else begin
      $display("matrix_vector_product test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("matrix_vector_product test failed");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/mvp_pkg.sv
hw/rtl/mvp_vec_store.sv
hw/rtl/mvp_mac_cell.sv
hw/rtl/mvp_accum.sv
hw/rtl/matrix_vector_product.sv
hw/rtl/mvp_checker.sv
test/tb.sv
